@@ src/tpd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_pkg: shared types and constants of the touch phase dimmer
// Field widths, event codes, fade codes and register indexes and reset values.
// ----------------------------------------------------------------------------
package tpd_pkg;

   // field widths
   localparam int unsigned OPCODE_W = 2;
   localparam int unsigned PADS_W   = 3;
   localparam int unsigned LEVEL_W  = 6;
   localparam int unsigned IDLE_W   = 8;
   localparam int unsigned SCAN_W   = 2;
   localparam int unsigned CSR_W    = 8;

   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [LEVEL_W-1:0]  level_type;
   typedef logic [IDLE_W-1:0]   idle_type;
   typedef logic [SCAN_W-1:0]   scan_type;
   typedef logic [1:0]          fade_type;
   typedef logic [0:0]          csr_index_type;

   // event codes; the spare code changes nothing
   localparam opcode_type OP_TICK  = 2'd0;
   localparam opcode_type OP_CROSS = 2'd1;
   localparam opcode_type OP_POLL  = 2'd2;
   localparam opcode_type OP_SPARE = 2'd3;

   // fade codes; the spare code is never produced and acts as no fade
   localparam fade_type FADE_NONE  = 2'd0;
   localparam fade_type FADE_DOWN  = 2'd1;
   localparam fade_type FADE_UP    = 2'd2;
   localparam fade_type FADE_SPARE = 2'd3;

   // register indexes
   localparam csr_index_type CSR_MAX_LEVEL  = 1'b0;
   localparam csr_index_type CSR_IDLE_LIMIT = 1'b1;

   // register reset values
   localparam level_type MAX_LEVEL_RST  = 6'd39;
   localparam idle_type  IDLE_LIMIT_RST = 8'd50;

endpackage : tpd_pkg
`default_nettype wire

@@ src/tpd_channels.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpd_channels: valid/ready channels of the touch phase dimmer
// Event channel into the block and result channel out of it.
// ----------------------------------------------------------------------------

// event channel: one event item per handshake
interface tpd_req_if;
   logic                        valid;
   logic                        ready;
   tpd_pkg::opcode_type         opcode;
   logic [tpd_pkg::PADS_W-1:0]  wheel_pads;
   logic                        power_pad;

   modport source (output valid, output opcode, output wheel_pads, output power_pad,
                   input ready);
   modport sink   (input valid, input opcode, input wheel_pads, input power_pad,
                   output ready);
endinterface : tpd_req_if

// result channel: lamp drive and level after each event
interface tpd_rsp_if;
   logic               valid;
   logic               ready;
   logic               lamp_on;
   tpd_pkg::level_type level;

   modport source (output valid, output lamp_on, output level, input ready);
   modport sink   (input valid, input lamp_on, input level, output ready);
endinterface : tpd_rsp_if
`default_nettype wire

@@ src/touch_phase_dimmer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_phase_dimmer: mains-synchronised phase-control lamp dimmer
// Handles tick, zero-crossing and pad-poll events and drives the lamp.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one event item per valid/ready handshake: a 250 us tick,
//   a mains zero crossing or a poll of the wheel pads and the on/off pad.
//   rsp_ch returns exactly one item per event: the lamp drive and the
//   brightness level after that event, in event order.
//   csr_we/csr_index/csr_wdata write max_level (index 0) and idle_limit
//   (index 1); write them only while no event is in flight.
// Timing:
//   An accepted event is latched in the input register; the state register
//   then updates the dimmer state and raises rsp_ch.valid once the result
//   slot is free or being emptied. One event per cycle is sustained while
//   rsp_ch.ready stays high, limited by the single state-update step.
// Reset (synchronous, active high) clears both stages, the lamp, the level,
//   the counters and the fade, and loads max_level 39 and idle_limit 50.
// Stall: while rsp_ch.ready is low the result holds; one more event is still
//   taken into the input register, then req_ch.ready drops until the result
//   is taken.
// ----------------------------------------------------------------------------
module touch_phase_dimmer (
   input  wire                    clock,
   input  wire                    reset,
   tpd_req_if.sink                req_ch,
   tpd_rsp_if.source              rsp_ch,
   input  wire                    csr_we,
   input  tpd_pkg::csr_index_type csr_index,
   input  wire [tpd_pkg::CSR_W-1:0] csr_wdata
);

   // configuration registers
   tpd_pkg::level_type max_level_ff;
   tpd_pkg::idle_type  idle_limit_ff;

   // input register
   logic                       in_valid_ff;
   tpd_pkg::opcode_type        op_ff;
   logic [tpd_pkg::PADS_W-1:0] pads_ff;
   logic                       power_ff;

   // dimmer state, lamp and level double as the result register
   logic                rsp_valid_ff;
   tpd_pkg::level_type  level_ff, level_in;
   tpd_pkg::level_type  tick_ff, tick_in;
   tpd_pkg::scan_type   scan_ff, scan_in;
   tpd_pkg::idle_type   idle_ff, idle_in;
   tpd_pkg::fade_type   fade_ff, fade_in;
   tpd_pkg::scan_type   pad_now_ff, pad_now_in;
   tpd_pkg::scan_type   pad_before_ff, pad_before_in;
   logic                lamp_ff, lamp_in;

   logic advance;
   logic step;

   // the state stage moves when the result slot is free or being emptied
   assign advance       = !rsp_valid_ff || rsp_ch.ready;
   assign step          = in_valid_ff && advance;
   assign req_ch.ready  = !in_valid_ff || advance;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.lamp_on = lamp_ff;
   assign rsp_ch.level   = level_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_level_ff  <= tpd_pkg::MAX_LEVEL_RST;
         idle_limit_ff <= tpd_pkg::IDLE_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            tpd_pkg::CSR_MAX_LEVEL:  max_level_ff  <= csr_wdata[tpd_pkg::LEVEL_W-1:0];
            tpd_pkg::CSR_IDLE_LIMIT: idle_limit_ff <= csr_wdata[tpd_pkg::IDLE_W-1:0];
            default: ;
         endcase
      end
   end

   // latch an accepted item, hold it while the result side stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         op_ff    <= req_ch.opcode;
         pads_ff  <= req_ch.wheel_pads;
         power_ff <= req_ch.power_pad;
      end
   end

   // next state for the latched event
   always_comb begin
      logic                expired;
      logic                hit;
      tpd_pkg::scan_type   down_from;
      tpd_pkg::scan_type   up_from;

      level_in      = level_ff;
      tick_in       = tick_ff;
      scan_in       = scan_ff;
      idle_in       = idle_ff;
      fade_in       = fade_ff;
      pad_now_in    = pad_now_ff;
      pad_before_in = pad_before_ff;
      lamp_in       = lamp_ff;
      expired       = 1'b0;
      hit           = 1'b0;
      down_from     = '0;
      up_from       = '0;

      unique case (op_ff)
         tpd_pkg::OP_TICK: begin
            // count the mark up to max_level, drop the lamp when it meets the level
            if (tick_ff < max_level_ff) begin
               tick_in = tick_ff + 6'd1;
            end
            if (level_ff != '0 && tick_in == level_ff) begin
               lamp_in = 1'b0;
            end
         end
         tpd_pkg::OP_CROSS: begin
            tick_in = '0;
            lamp_in = (level_ff != '0);
            if (scan_ff != 2'd3) begin
               scan_in = scan_ff + 2'd1;
            end else begin
               // every third crossing: one fade step, saturating at both ends
               scan_in = 2'd1;
               if (fade_ff == tpd_pkg::FADE_DOWN) begin
                  if (level_ff != '0) begin
                     level_in = level_ff - 6'd1;
                  end
                  if (level_in == '0) begin
                     fade_in = tpd_pkg::FADE_NONE;
                  end
               end else if (fade_ff == tpd_pkg::FADE_UP) begin
                  if (level_ff < max_level_ff) begin
                     level_in = level_ff + 6'd1;
                  end
                  if (level_in >= max_level_ff) begin
                     fade_in = tpd_pkg::FADE_NONE;
                  end
               end
            end
            if (idle_ff < idle_limit_ff) begin
               idle_in = idle_ff + 8'd1;
            end
         end
         tpd_pkg::OP_POLL: begin
            // clear the wheel history after a long quiet spell
            expired = (idle_ff >= idle_limit_ff);
            if (expired) begin
               pad_before_in = '0;
               pad_now_in    = '0;
               if (pads_ff != '0) begin
                  idle_in = '0;
                  scan_in = 2'd1;
               end
            end
            if (idle_in < idle_limit_ff) begin
               // sample the pad picked by the scan phase
               if (scan_in != '0) begin
                  hit = pads_ff[scan_in - 2'd1];
                  if (hit) begin
                     pad_before_in = pad_now_in;
                     pad_now_in    = scan_in;
                     idle_in       = '0;
                  end
               end
               // decode wheel direction from the last two pads
               if (pad_before_in != pad_now_in && pad_now_in != '0) begin
                  down_from = (pad_now_in == 2'd3) ? 2'd1 : pad_now_in + 2'd1;
                  up_from   = (pad_now_in == 2'd1) ? 2'd3 : pad_now_in - 2'd1;
                  if (pad_before_in == down_from) begin
                     if (level_ff != '0) begin
                        level_in = level_ff - 6'd1;
                     end
                  end else if (pad_before_in == up_from) begin
                     if (level_ff < max_level_ff) begin
                        level_in = level_ff + 6'd1;
                     end
                  end
                  pad_before_in = '0;
               end
            end
            // arm the fade from the on/off pad
            if (power_ff) begin
               fade_in = (level_in != '0) ? tpd_pkg::FADE_DOWN : tpd_pkg::FADE_UP;
            end
         end
         default: ;
      endcase
   end

   // advance the state and the result slot
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         level_ff      <= '0;
         tick_ff       <= '0;
         scan_ff       <= '0;
         idle_ff       <= '0;
         fade_ff       <= tpd_pkg::FADE_NONE;
         pad_now_ff    <= '0;
         pad_before_ff <= '0;
         lamp_ff       <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
         if (step) begin
            level_ff      <= level_in;
            tick_ff       <= tick_in;
            scan_ff       <= scan_in;
            idle_ff       <= idle_in;
            fade_ff       <= fade_in;
            pad_now_ff    <= pad_now_in;
            pad_before_ff <= pad_before_in;
            lamp_ff       <= lamp_in;
         end
      end
   end

   // reset empties both stages
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !in_valid_ff)
      else $error("stage not emptied by reset");

   // a latched item is never dropped while the result side stalls
   a_hold_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(op_ff))
      else $error("latched item lost during stall");

   // the spare fade code is never produced
   a_fade_code: assert property (@(posedge clock) disable iff (reset)
      fade_ff != tpd_pkg::FADE_SPARE)
      else $error("reserved fade code reached");

   // a processed crossing always leaves a valid scan phase and a cleared mark
   a_scan_phase: assert property (@(posedge clock) disable iff (reset)
      step && op_ff == tpd_pkg::OP_CROSS |=> scan_ff != '0 && tick_ff == '0)
      else $error("crossing left scan phase or mark wrong");

endmodule : touch_phase_dimmer
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the touch phase dimmer
// Streams tick, zero-crossing and pad-poll items into the block, predicts the
// lamp drive and level for each one and checks every result item in order.
// The run walks through several register settings and idling patterns.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned PHASE_ITEMS = 350;

   typedef struct packed {
      tpd_pkg::opcode_type        opcode;
      logic [tpd_pkg::PADS_W-1:0] wheel_pads;
      logic                       power_pad;
   } dimmer_event_type;

   typedef struct packed {
      logic               lamp_on;
      tpd_pkg::level_type level;
   } lamp_level_type;

   typedef struct {
      tpd_pkg::level_type max_level;
      tpd_pkg::idle_type  idle_limit;
      tpd_pkg::level_type level;
      tpd_pkg::level_type mark;
      tpd_pkg::scan_type  scan;
      tpd_pkg::idle_type  idle;
      tpd_pkg::fade_type  fade;
      logic [1:0]         pad_now;
      logic [1:0]         pad_before;
      logic               lamp;
   } dimmer_state_type;

   logic clock;
   logic reset;
   logic csr_we;
   tpd_pkg::csr_index_type csr_index;
   logic [tpd_pkg::CSR_W-1:0] csr_wdata;

   tpd_req_if req_ch ();
   tpd_rsp_if rsp_ch ();

   touch_phase_dimmer dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // plan_state runs ahead as items are queued; live_state follows accepted items
   dimmer_state_type plan_state;
   dimmer_state_type live_state;
   dimmer_event_type event_backlog[$];
   lamp_level_type   lamp_level_due[$];

   int unsigned queued_count;
   int unsigned accepted_count;
   int unsigned results_checked;
   int unsigned error_count;
   int unsigned cycle_count;
   int unsigned settings_used;
   int unsigned op_seen[4];
   int unsigned send_idle_pct;
   int unsigned stall_pct;
   logic        req_fired;

   // clock: 2 ns period
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic dimmer_state_type dimmer_reset_state();
      dimmer_state_type st;
      st.max_level  = tpd_pkg::MAX_LEVEL_RST;
      st.idle_limit = tpd_pkg::IDLE_LIMIT_RST;
      st.level      = '0;
      st.mark       = '0;
      st.scan       = '0;
      st.idle       = '0;
      st.fade       = tpd_pkg::FADE_NONE;
      st.pad_now    = '0;
      st.pad_before = '0;
      st.lamp       = 1'b0;
      return st;
   endfunction

   // nudge the level one step, saturating at zero and at max_level
   function automatic void nudge_level(inout dimmer_state_type st, input logic up);
      if (up) begin
         if (st.level < st.max_level)
            st.level = st.level + 1'b1;
      end else if (st.level != 0) begin
         st.level = st.level - 1'b1;
      end
   endfunction

   // advance the dimmer by one event and return the lamp drive and level
   function automatic lamp_level_type dimmer_next(inout dimmer_state_type st,
                                                  input dimmer_event_type ev);
      lamp_level_type res;
      logic [1:0]     down_from;
      logic [1:0]     up_from;
      case (ev.opcode)
         tpd_pkg::OP_TICK: begin
            if (st.mark < st.max_level)
               st.mark = st.mark + 1'b1;
            if (st.level != 0 && st.mark == st.level)
               st.lamp = 1'b0;
         end
         tpd_pkg::OP_CROSS: begin
            st.mark = '0;
            st.lamp = (st.level != 0);
            if (st.scan < 2'd3) begin
               st.scan = st.scan + 1'b1;
            end else begin
               // every third crossing steps the fade
               st.scan = 2'd1;
               if (st.fade == tpd_pkg::FADE_DOWN) begin
                  nudge_level(st, 1'b0);
                  if (st.level == 0)
                     st.fade = tpd_pkg::FADE_NONE;
               end else if (st.fade == tpd_pkg::FADE_UP) begin
                  nudge_level(st, 1'b1);
                  if (st.level >= st.max_level)
                     st.fade = tpd_pkg::FADE_NONE;
               end
            end
            if (st.idle < st.idle_limit)
               st.idle = st.idle + 1'b1;
         end
         tpd_pkg::OP_POLL: begin
            // idle timeout: drop wheel history, restart scan on a touch
            if (st.idle >= st.idle_limit) begin
               st.pad_before = '0;
               st.pad_now    = '0;
               if (ev.wheel_pads != 0) begin
                  st.idle = '0;
                  st.scan = 2'd1;
               end
            end
            if (st.idle < st.idle_limit) begin
               if (st.scan != 0 && ev.wheel_pads[st.scan - 2'd1]) begin
                  st.pad_before = st.pad_now;
                  st.pad_now    = st.scan;
                  st.idle       = '0;
               end
               // decode wheel direction from the last two pads
               if (st.pad_before != st.pad_now && st.pad_now != 0) begin
                  down_from = (st.pad_now == 2'd3) ? 2'd1 : st.pad_now + 2'd1;
                  up_from   = (st.pad_now == 2'd1) ? 2'd3 : st.pad_now - 2'd1;
                  if (st.pad_before == down_from)
                     nudge_level(st, 1'b0);
                  else if (st.pad_before == up_from)
                     nudge_level(st, 1'b1);
                  st.pad_before = '0;
               end
            end
            if (ev.power_pad)
               st.fade = (st.level != 0) ? tpd_pkg::FADE_DOWN : tpd_pkg::FADE_UP;
         end
         default: begin
         end
      endcase
      res.lamp_on = st.lamp;
      res.level   = st.level;
      return res;
   endfunction

   // queue one item and track the state it leads to
   task automatic queue_event(input tpd_pkg::opcode_type op, input logic [2:0] pads,
                              input logic power);
      dimmer_event_type ev;
      ev.opcode     = op;
      ev.wheel_pads = pads;
      ev.power_pad  = power;
      void'(dimmer_next(plan_state, ev));
      event_backlog.push_back(ev);
      queued_count++;
   endtask

   // hold until every queued item is accepted and answered, then settle
   task automatic wait_drained();
      while (accepted_count != queued_count || lamp_level_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input tpd_pkg::csr_index_type idx,
                            input logic [tpd_pkg::CSR_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == tpd_pkg::CSR_MAX_LEVEL) begin
         plan_state.max_level = data[tpd_pkg::LEVEL_W-1:0];
         live_state.max_level = data[tpd_pkg::LEVEL_W-1:0];
      end else begin
         plan_state.idle_limit = data;
         live_state.idle_limit = data;
      end
   endtask

   // half periods: one crossing, then mostly ticks with polls and some noise
   task automatic queue_random(input int unsigned count);
      int unsigned made;
      int unsigned burst;
      int unsigned pick;
      int unsigned sel;
      logic [2:0]  pads;
      made = 0;
      while (made < count) begin
         queue_event(tpd_pkg::OP_CROSS, 3'($urandom_range(7)), 1'($urandom_range(1)));
         made++;
         burst = $urandom_range(plan_state.max_level + 3);
         repeat (burst) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
               queue_event(tpd_pkg::OP_TICK, 3'($urandom_range(7)),
                           1'($urandom_range(1)));
            end else if (pick < 93) begin
               sel = $urandom_range(9);
               if (sel < 5)
                  pads = (plan_state.scan == 0) ? 3'b001 : 3'b001 << (plan_state.scan - 1);
               else if (sel == 5)
                  pads = 3'b111;
               else if (sel == 6)
                  pads = 3'b000;
               else
                  pads = 3'($urandom_range(7));
               queue_event(tpd_pkg::OP_POLL, pads, $urandom_range(19) == 0);
            end else begin
               queue_event(tpd_pkg::opcode_type'($urandom_range(3)), 3'($urandom_range(7)),
                           1'($urandom_range(1)));
            end
            made++;
         end
      end
   endtask

   task automatic run_phase(input tpd_pkg::level_type max_lvl, input tpd_pkg::idle_type lim,
                            input int unsigned send_pct, input int unsigned hold_pct);
      write_csr(tpd_pkg::CSR_MAX_LEVEL, tpd_pkg::CSR_W'(max_lvl));
      write_csr(tpd_pkg::CSR_IDLE_LIMIT, lim);
      settings_used++;
      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
      queue_random(PHASE_ITEMS);
      wait_drained();
   endtask

   // drive the event channel from the backlog
   always @(negedge clock) begin : drive_events
      dimmer_event_type nxt;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fired) begin
         if (event_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = event_backlog.pop_front();
            req_ch.valid      <= 1'b1;
            req_ch.opcode     <= nxt.opcode;
            req_ch.wheel_pads <= nxt.wheel_pads;
            req_ch.power_pad  <= nxt.power_pad;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // stall the result channel at random
   always @(negedge clock) begin : drive_ready
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // sample both channels, check results and predict accepted items
   always @(posedge clock) begin : watch_ports
      dimmer_event_type ev;
      lamp_level_type   got;
      lamp_level_type   want;
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stalled after %0d cycles, %0d results outstanding",
                  $time, cycle_count, lamp_level_due.size());
         $display("TB_ERROR");
         $finish;
      end else if (reset) begin
         req_fired = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.lamp_on = rsp_ch.lamp_on;
            got.level   = rsp_ch.level;
            if (lamp_level_due.size() == 0) begin
               error_count++;
               $display("%0t: result item with none expected: lamp %0b level %0d",
                        $time, got.lamp_on, got.level);
            end else begin
               want = lamp_level_due.pop_front();
               results_checked++;
               if (got.lamp_on !== want.lamp_on) begin
                  error_count++;
                  $display("%0t: lamp_on expected %0b actual %0b",
                           $time, want.lamp_on, got.lamp_on);
               end
               if (got.level !== want.level) begin
                  error_count++;
                  $display("%0t: level expected %0d actual %0d",
                           $time, want.level, got.level);
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            ev.opcode     = req_ch.opcode;
            ev.wheel_pads = req_ch.wheel_pads;
            ev.power_pad  = req_ch.power_pad;
            lamp_level_due.push_back(dimmer_next(live_state, ev));
            op_seen[ev.opcode]++;
            accepted_count++;
         end
         req_fired = req_ch.valid && req_ch.ready;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = tpd_pkg::CSR_MAX_LEVEL;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.opcode     = tpd_pkg::OP_TICK;
      req_ch.wheel_pads = '0;
      req_ch.power_pad  = 1'b0;
      rsp_ch.ready      = 1'b0;
      req_fired         = 1'b0;
      queued_count      = 0;
      accepted_count    = 0;
      results_checked   = 0;
      error_count       = 0;
      cycle_count       = 0;
      settings_used     = 1;
      send_idle_pct     = 0;
      stall_pct         = 0;
      op_seen           = '{default: 0};
      plan_state        = dimmer_reset_state();
      live_state        = dimmer_reset_state();

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: spare code, empty tick, power-on fade, wheel both ways
      queue_event(tpd_pkg::OP_SPARE, 3'b111, 1'b1);
      queue_event(tpd_pkg::OP_TICK, 3'b000, 1'b0);
      queue_event(tpd_pkg::OP_POLL, 3'b000, 1'b1);
      repeat (4) queue_event(tpd_pkg::OP_CROSS, 3'b000, 1'b0);
      queue_event(tpd_pkg::OP_POLL, 3'b111, 1'b0);
      queue_event(tpd_pkg::OP_CROSS, 3'b000, 1'b0);
      queue_event(tpd_pkg::OP_POLL, 3'b111, 1'b0);
      queue_event(tpd_pkg::OP_CROSS, 3'b000, 1'b0);
      queue_event(tpd_pkg::OP_POLL, 3'b100, 1'b0);
      queue_event(tpd_pkg::OP_CROSS, 3'b000, 1'b0);
      queue_event(tpd_pkg::OP_POLL, 3'b001, 1'b0);
      repeat (6) queue_event(tpd_pkg::OP_TICK, 3'b000, 1'b0);
      queue_event(tpd_pkg::OP_CROSS, 3'b000, 1'b0);
      queue_event(tpd_pkg::OP_CROSS, 3'b000, 1'b0);
      queue_event(tpd_pkg::OP_POLL, 3'b100, 1'b0);
      queue_event(tpd_pkg::OP_POLL, 3'b000, 1'b1);
      queue_event(tpd_pkg::OP_POLL, 3'b000, 1'b0);
      wait_drained();

      // random phases; dropping both limits after the widest setting leaves
      // the level and the idle count above their new limits
      run_phase(tpd_pkg::MAX_LEVEL_RST, tpd_pkg::IDLE_LIMIT_RST, 0, 0);
      run_phase(6'd63, 8'd255, 47, 0);
      run_phase(6'd1, 8'd1, 0, 47);
      run_phase(6'd12, 8'd3, 28, 28);
      run_phase(6'd20, 8'd170, 0, 0);

      $display("Checked %0d results: %0d ticks, %0d crossings, %0d polls, %0d spare codes",
               results_checked, op_seen[tpd_pkg::OP_TICK], op_seen[tpd_pkg::OP_CROSS],
               op_seen[tpd_pkg::OP_POLL], op_seen[tpd_pkg::OP_SPARE]);
      $display("Register settings used: %0d, mismatches: %0d", settings_used, error_count);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule : testbench
